// ===== src/thumb_alu_shift_add_execute_top_defines.svh =====
// ----------------------------------------------------------------------------
// Thumb ALU execute - assertion macros
// Shared concurrent assertion forms for the execute block.
// ----------------------------------------------------------------------------
`ifndef THUMB_ALU_SHIFT_ADD_EXECUTE_TOP_DEFINES_SVH
`define THUMB_ALU_SHIFT_ADD_EXECUTE_TOP_DEFINES_SVH

// same-cycle implication
`define TASE_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define TASE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/tase_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Thumb ALU execute package
// Operation codes, flag and result types, and sizing defaults.
// ----------------------------------------------------------------------------
package tase_pkg;

   localparam int REG_COUNT_DEF = 8;
   localparam int DATA_W        = 32;
   localparam int INDEX_W       = 3;
   localparam int OP_W          = 4;
   localparam int IMM_W         = 8;

   typedef enum logic [OP_W-1:0] {
      OP_ADD_REG  = 4'd0,
      OP_SUB_REG  = 4'd1,
      OP_ADD_IMM3 = 4'd2,
      OP_SUB_IMM3 = 4'd3,
      OP_ADD_IMM8 = 4'd4,
      OP_SUB_IMM8 = 4'd5,
      OP_MOV_IMM8 = 4'd6,
      OP_CMP_IMM8 = 4'd7,
      OP_LSL      = 4'd8,
      OP_LSR      = 4'd9,
      OP_ASR      = 4'd10
   } op_type;

   typedef struct packed {
      logic n;
      logic z;
      logic c;
      logic v;
   } flags_type;

   typedef struct packed {
      logic              valid;
      logic              we;
      logic [DATA_W-1:0] value;
      flags_type         flags;
   } alu_result_type;

endpackage
`default_nettype wire

// ===== src/tase_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, two read ports with registered read data.
// ----------------------------------------------------------------------------
module tase_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 8,
   localparam int AW   = $clog2(DEPTH)
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr_a,
   input  wire logic [AW-1:0]    rd_addr_b,
   output logic      [WIDTH-1:0] rd_data_a,
   output logic      [WIDTH-1:0] rd_data_b
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_a <= mem[rd_addr_a];
         rd_data_b <= mem[rd_addr_b];
      end
   end

endmodule
`default_nettype wire

// ===== src/tase_alu.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Thumb ALU datapath
// Add/subtract, move, compare and immediate shifts with NZCV update.
// ----------------------------------------------------------------------------
module tase_alu
   import tase_pkg::*;
(
   input  wire logic [OP_W-1:0]   operation,
   input  wire logic [IMM_W-1:0]  immediate,
   input  wire logic [DATA_W-1:0] src_a,
   input  wire logic [DATA_W-1:0] src_b,
   input  wire flags_type         flags,
   output alu_result_type         result
);

   logic              sub;
   logic [DATA_W-1:0] opb;
   logic [DATA_W-1:0] addend;
   logic [DATA_W:0]   sum;
   logic              ovf;
   logic [4:0]        shamt;
   logic [5:0]        amt;
   logic [DATA_W:0]   lsl_w;
   logic [DATA_W:0]   lsr_w;
   logic [DATA_W:0]   asr_w;

   always_comb begin
      sub = 1'b0;
      opb = '0;
      case (operation)
         OP_ADD_REG:  opb = src_b;
         OP_SUB_REG:  begin sub = 1'b1; opb = src_b; end
         OP_ADD_IMM3: opb = DATA_W'(immediate[2:0]);
         OP_SUB_IMM3: begin sub = 1'b1; opb = DATA_W'(immediate[2:0]); end
         OP_ADD_IMM8: opb = DATA_W'(immediate);
         OP_SUB_IMM8, OP_CMP_IMM8: begin
            sub = 1'b1;
            opb = DATA_W'(immediate);
         end
         default:     opb = '0;
      endcase
   end

   // subtract as a + ~b + 1, carry out is NOT borrow
   assign addend = sub ? ~opb : opb;
   assign sum    = {1'b0, src_a} + {1'b0, addend} + (DATA_W+1)'(sub);
   assign ovf    = (sub ? (src_a[DATA_W-1] ^ opb[DATA_W-1])
                        : ~(src_a[DATA_W-1] ^ opb[DATA_W-1]))
                   & (src_a[DATA_W-1] ^ sum[DATA_W-1]);

   // right shifts by zero encode a shift by 32
   assign shamt = immediate[4:0];
   assign amt   = (shamt == 5'd0) ? 6'd32 : {1'b0, shamt};
   assign lsl_w = {1'b0, src_b} << shamt;
   assign lsr_w = {src_b, 1'b0} >> amt;
   assign asr_w = (DATA_W+1)'($signed({src_b, 1'b0}) >>> amt);

   always_comb begin
      result.valid = 1'b1;
      result.we    = 1'b1;
      result.value = '0;
      result.flags = flags;
      case (operation)
         OP_ADD_REG, OP_SUB_REG, OP_ADD_IMM3, OP_SUB_IMM3,
         OP_ADD_IMM8, OP_SUB_IMM8: begin
            result.value   = sum[DATA_W-1:0];
            result.flags.c = sum[DATA_W];
            result.flags.v = ovf;
         end
         OP_CMP_IMM8: begin
            result.we      = 1'b0;
            result.value   = sum[DATA_W-1:0];
            result.flags.c = sum[DATA_W];
            result.flags.v = ovf;
         end
         OP_MOV_IMM8: result.value = DATA_W'(immediate);
         OP_LSL: begin
            result.value = lsl_w[DATA_W-1:0];
            if (shamt != 5'd0) begin
               result.flags.c = lsl_w[DATA_W];
            end
         end
         OP_LSR: begin
            result.value   = lsr_w[DATA_W:1];
            result.flags.c = lsr_w[0];
         end
         OP_ASR: begin
            result.value   = asr_w[DATA_W:1];
            result.flags.c = asr_w[0];
         end
         default: begin
            result.valid = 1'b0;
            result.we    = 1'b0;
         end
      endcase
      if (result.valid) begin
         result.flags.n = result.value[DATA_W-1];
         result.flags.z = (result.value == '0);
      end
   end

endmodule
`default_nettype wire

// ===== src/thumb_alu_shift_add_execute_top.sv =====
// A request passes the input register, then the result register, which drives rsp_*.
// Throughput: one request per cycle unless rsp_stall holds a result; register file and
// flags update as a request leaves the input register: no bubble for the next request.
// Reset (synchronous, active high): pipeline empties, flags clear, and per-register
// valid bits make every register read as zero until it is first written.
`timescale 1ns / 1ps
`default_nettype none
`include "thumb_alu_shift_add_execute_top_defines.svh"
// ----------------------------------------------------------------------------
// Thumb ALU execute top
// Input register, register-file read with bypass, ALU, result register.
// ----------------------------------------------------------------------------
module thumb_alu_shift_add_execute_top
   import tase_pkg::*;
#(
   parameter int REG_COUNT = REG_COUNT_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic [OP_W-1:0]    req_operation,
   input  wire logic [INDEX_W-1:0] req_dest_index,
   input  wire logic [INDEX_W-1:0] req_first_index,
   input  wire logic [INDEX_W-1:0] req_second_index,
   input  wire logic [IMM_W-1:0]   req_immediate,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic                    rsp_write_enable,
   output logic [INDEX_W-1:0]      rsp_write_index,
   output logic [DATA_W-1:0]       rsp_write_value,
   output logic                    rsp_negative_flag,
   output logic                    rsp_zero_flag,
   output logic                    rsp_carry_flag,
   output logic                    rsp_overflow_flag
);

   localparam int AW = $clog2(REG_COUNT);

   logic                 accept;
   logic                 advance;
   logic [AW-1:0]        addr_a;
   logic [AW-1:0]        addr_b;
   logic [AW-1:0]        wr_addr;
   logic                 wr_en;
   logic [DATA_W-1:0]    ram_a;
   logic [DATA_W-1:0]    ram_b;
   logic [DATA_W-1:0]    src_a;
   logic [DATA_W-1:0]    src_b;
   alu_result_type       res;

   logic                 in_valid_ff,  in_valid_in;
   logic [OP_W-1:0]      op_ff,        op_in;
   logic [INDEX_W-1:0]   rd_ff,        rd_in;
   logic [IMM_W-1:0]     imm_ff,       imm_in;
   logic                 byp_a_ff,     byp_a_in;
   logic                 byp_b_ff,     byp_b_in;
   logic [DATA_W-1:0]    byp_val_ff,   byp_val_in;
   logic                 vld_a_ff,     vld_a_in;
   logic                 vld_b_ff,     vld_b_in;
   logic [REG_COUNT-1:0] reg_vld_ff,   reg_vld_in;
   flags_type            flags_ff,     flags_in;
   logic                 out_valid_ff, out_valid_in;
   logic                 out_we_ff,    out_we_in;
   logic [INDEX_W-1:0]   out_idx_ff,   out_idx_in;
   logic [DATA_W-1:0]    out_val_ff,   out_val_in;
   flags_type            out_flags_ff, out_flags_in;

   assign advance   = in_valid_ff & (~out_valid_ff | ~rsp_stall);
   assign req_stall = in_valid_ff & ~advance;
   assign accept    = req_valid & ~req_stall;

   // port A: Rn for the low-register forms, Rd for the imm8 forms
   assign addr_a = (req_operation inside {OP_ADD_REG, OP_SUB_REG, OP_ADD_IMM3, OP_SUB_IMM3})
                   ? AW'(req_first_index) : AW'(req_dest_index);
   assign addr_b = AW'(req_second_index);

   assign wr_en   = advance & res.we;
   assign wr_addr = AW'(rd_ff);

   tase_ram #(
      .WIDTH (DATA_W),
      .DEPTH (REG_COUNT)
   ) u_regfile (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (res.value),
      .rd_en     (accept),
      .rd_addr_a (addr_a),
      .rd_addr_b (addr_b),
      .rd_data_a (ram_a),
      .rd_data_b (ram_b)
   );

   assign src_a = byp_a_ff ? byp_val_ff : (vld_a_ff ? ram_a : '0);
   assign src_b = byp_b_ff ? byp_val_ff : (vld_b_ff ? ram_b : '0);

   tase_alu u_alu (
      .operation (op_ff),
      .immediate (imm_ff),
      .src_a     (src_a),
      .src_b     (src_b),
      .flags     (flags_ff),
      .result    (res)
   );

   always_comb begin
      in_valid_in = accept | (in_valid_ff & ~advance);
      op_in       = op_ff;
      rd_in       = rd_ff;
      imm_in      = imm_ff;
      byp_a_in    = byp_a_ff;
      byp_b_in    = byp_b_ff;
      byp_val_in  = byp_val_ff;
      vld_a_in    = vld_a_ff;
      vld_b_in    = vld_b_ff;
      if (accept) begin
         op_in      = req_operation;
         rd_in      = req_dest_index;
         imm_in     = req_immediate;
         // write leaving this cycle is not yet visible in the RAM read
         byp_a_in   = wr_en & (wr_addr == addr_a);
         byp_b_in   = wr_en & (wr_addr == addr_b);
         byp_val_in = res.value;
         vld_a_in   = reg_vld_ff[addr_a];
         vld_b_in   = reg_vld_ff[addr_b];
      end
   end

   always_comb begin
      reg_vld_in = reg_vld_ff;
      if (wr_en) begin
         reg_vld_in[wr_addr] = 1'b1;
      end
      flags_in = (advance & res.valid) ? res.flags : flags_ff;
   end

   always_comb begin
      out_valid_in = advance | (out_valid_ff & rsp_stall);
      out_we_in    = out_we_ff;
      out_idx_in   = out_idx_ff;
      out_val_in   = out_val_ff;
      out_flags_in = out_flags_ff;
      if (advance) begin
         out_we_in    = res.we;
         out_idx_in   = rd_ff;
         out_val_in   = res.value;
         out_flags_in = res.flags;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         reg_vld_ff   <= '0;
         flags_ff     <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         reg_vld_ff   <= reg_vld_in;
         flags_ff     <= flags_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      rd_ff        <= rd_in;
      imm_ff       <= imm_in;
      byp_a_ff     <= byp_a_in;
      byp_b_ff     <= byp_b_in;
      byp_val_ff   <= byp_val_in;
      vld_a_ff     <= vld_a_in;
      vld_b_ff     <= vld_b_in;
      out_we_ff    <= out_we_in;
      out_idx_ff   <= out_idx_in;
      out_val_ff   <= out_val_in;
      out_flags_ff <= out_flags_in;
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_write_enable  = out_we_ff;
   assign rsp_write_index   = out_idx_ff;
   assign rsp_write_value   = out_val_ff;
   assign rsp_negative_flag = out_flags_ff.n;
   assign rsp_zero_flag     = out_flags_ff.z;
   assign rsp_carry_flag    = out_flags_ff.c;
   assign rsp_overflow_flag = out_flags_ff.v;

   `TASE_ASSERT_NEXT(a_hold_blocked, clock, reset, in_valid_ff && !advance, in_valid_ff, "blocked request lost")
   `TASE_ASSERT_NEXT(a_cmp_no_write, clock, reset, advance && (op_ff == OP_CMP_IMM8), !rsp_write_enable, "compare wrote a register")
   `TASE_ASSERT_NEXT(a_undef_flags, clock, reset, advance && !res.valid, $stable(flags_ff), "undefined op changed flags")
   `TASE_ASSERT_NOW(a_wr_valid_set, clock, reset, wr_en, advance && res.valid, "register write without a valid request")

endmodule
`default_nettype wire
